@@ hw/rtl/bellman_ford_shortest_paths_assert.svh @@
// Assertion macros for the shortest-path RTL.
// Expects signals named clk and rst_n in the including module.
`ifndef BELLMAN_FORD_SHORTEST_PATHS_ASSERT_SVH
`define BELLMAN_FORD_SHORTEST_PATHS_ASSERT_SVH

// Same-cycle implication, ignored while in reset.
`define BFSP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bfsp: assertion failed");

// Next-cycle implication, ignored while in reset.
`define BFSP_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bfsp: assertion failed");

`endif

@@ hw/rtl/bfsp_pkg.sv @@
// Shared constants, types and sequencer states for the shortest-path block.
// No dependencies.
`default_nettype none

package bfsp_pkg;

    // Sizing
    localparam int MAX_NODES   = 16;
    localparam int WEIGHT_BITS = 16;
    localparam int NODE_W      = $clog2(MAX_NODES);
    localparam int CNT_W       = $clog2(MAX_NODES + 1);
    localparam int ADDR_W      = 2 * NODE_W;
    localparam int MAT_DEPTH   = MAX_NODES * MAX_NODES;
    // A stored distance is always a simple path: it visits each node at most once.
    localparam longint unsigned MAX_PATH =
        longint'(MAX_NODES - 1) * ((64'd1 << WEIGHT_BITS) - 64'd1);
    localparam int DIST_W      = $clog2(MAX_PATH + 64'd1);

    // Port field widths
    localparam int ROW_W       = 4;
    localparam int WIN_W       = 16;
    localparam int SRC_W       = 4;
    localparam int COUNT_W     = 5;
    localparam int OUT_NODE_W  = 4;
    localparam int OUT_DIST_W  = 20;
    localparam int PARENT_W    = 5;
    localparam int CFG_DATA_W  = 5;
    localparam int CFG_ADDR_W  = 1;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_SOURCE_NODE = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_NODE_COUNT  = 1'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_ROW_RD,
        ST_ROW_CHK,
        ST_SCAN,
        ST_DRAIN,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_OUT_SEND
    } bfsp_state_t;

    // Sequencer -> weight RAM / relax unit / output register
    typedef struct packed {
        logic              clear;     // drop all reached flags
        logic              seed;      // mark source reached at distance 0
        logic [NODE_W-1:0] seed_addr;
        logic [NODE_W-1:0] rd_addr;   // table read address (u or v)
        logic [NODE_W-1:0] u;         // current row
        logic              relax;     // read at rd_addr is a relaxation of (u, v)
        logic              latch_u;   // capture dist[u] from the read data
        logic              out_load;  // load the output register
        logic              out_last;
    } bfsp_ctl_t;

    // Relax unit read data
    typedef struct packed {
        logic              fin;
        logic [DIST_W-1:0] dist_val;
        logic [CNT_W-1:0]  parent;
    } bfsp_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/bellman_ford_shortest_paths.sv @@
// Single-source shortest paths over a loaded adjacency matrix (Bellman-Ford).
// Input channel (in_valid/in_ready) carries one matrix entry per item:
// row_index, col_index, edge_weight (0 = no edge) and last_entry. Entries
// are written into the weight RAM at one item per cycle while idle.
// An item with last_entry set stores its entry and starts a run from
// source_node over the first node_count nodes (saturated to MAX_NODES).
// A run makes n-1 passes; each pass walks rows u in order, relaxing each
// (u, v) through a single add-compare unit. A row whose node is not yet
// reached is skipped after its check; a reached row reads dist[u], then
// scans v = 0..n-1 and drains before the next row.
// Results then leave on out_valid/out_ready, one item per node 0..n-1,
// each taken before the next is read; last_node flags node n-1. node_count 0
// gives no items. in_ready is low from the start of a run until the last
// result is taken; a stalled receiver simply holds the sequencer in place.
// Config writes (cfg_wr_en/cfg_addr/cfg_wdata) take effect at once; the user
// must issue them only while the block is idle, which the block does not
// enforce. Reset: source 0, node_count 16, sequencer idle. The weight RAM is
// not cleared; read an entry only after writing it.
// Depends on bfsp_pkg, bfsp_wmem, bfsp_relax, bfsp_seq.
`default_nettype none

module bellman_ford_shortest_paths (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration
    input  wire logic                           cfg_wr_en,
    input  wire logic [bfsp_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [bfsp_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // matrix entries
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [bfsp_pkg::ROW_W-1:0]      row_index,
    input  wire logic [bfsp_pkg::ROW_W-1:0]      col_index,
    input  wire logic [bfsp_pkg::WIN_W-1:0]      edge_weight,
    input  wire logic                           last_entry,
    // per-node results
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic      [bfsp_pkg::OUT_NODE_W-1:0] node_index,
    output logic      [bfsp_pkg::OUT_DIST_W-1:0] path_distance,
    output logic                                reachable,
    output logic      [bfsp_pkg::PARENT_W-1:0]   parent_node,
    output logic                                last_node
);
    import bfsp_pkg::*;

    logic [SRC_W-1:0]       source_node_reg;
    logic [COUNT_W-1:0]     node_count_reg;

    logic                   in_fire;
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic [WEIGHT_BITS-1:0] rd_weight;

    bfsp_ctl_t              ctl;
    bfsp_stat_t             stat;

    logic                   out_valid_reg;
    logic [OUT_NODE_W-1:0]  node_index_reg;
    logic [OUT_DIST_W-1:0]  path_distance_reg;
    logic                   reachable_reg;
    logic [PARENT_W-1:0]    parent_node_reg;
    logic                   last_node_reg;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_node_reg <= '0;
            node_count_reg  <= COUNT_W'(16);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_SOURCE_NODE: source_node_reg <= SRC_W'(cfg_wdata);
                REG_NODE_COUNT:  node_count_reg  <= COUNT_W'(cfg_wdata);
            endcase
        end
    end

    // entry load: out-of-range rows/cols are dropped
    assign in_fire = in_valid && in_ready;
    assign wr_en   = in_fire && (32'(row_index) < MAX_NODES) && (32'(col_index) < MAX_NODES);
    assign wr_addr = {NODE_W'(row_index), NODE_W'(col_index)};

    bfsp_wmem u_wmem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (WEIGHT_BITS'(edge_weight)),
        .rd_addr ({ctl.u, ctl.rd_addr}),
        .rd_data (rd_weight)
    );

    bfsp_relax u_relax (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .weight (rd_weight),
        .stat   (stat)
    );

    bfsp_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .last_entry  (last_entry),
        .source_node (source_node_reg),
        .node_count  (node_count_reg),
        .out_ready   (out_ready),
        .status      (stat),
        .in_ready    (in_ready),
        .ctl         (ctl)
    );

    // output register; unreached nodes report zero distance and parent
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_valid_reg && out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            node_index_reg    <= OUT_NODE_W'(ctl.rd_addr);
            path_distance_reg <= stat.fin ? OUT_DIST_W'(stat.dist_val) : '0;
            reachable_reg     <= stat.fin;
            parent_node_reg   <= stat.fin ? PARENT_W'(stat.parent) : '0;
            last_node_reg     <= ctl.out_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign node_index    = node_index_reg;
    assign path_distance = path_distance_reg;
    assign reachable     = reachable_reg;
    assign parent_node   = parent_node_reg;
    assign last_node     = last_node_reg;

endmodule

`default_nettype wire

@@ hw/rtl/bfsp_wmem.sv @@
// Weight matrix storage: one write port, one registered read port.
// Depends on bfsp_pkg.
`default_nettype none

module bfsp_wmem (
    input  wire logic                            clk,
    input  wire logic                            wr_en,
    input  wire logic [bfsp_pkg::ADDR_W-1:0]      wr_addr,
    input  wire logic [bfsp_pkg::WEIGHT_BITS-1:0] wr_data,
    input  wire logic [bfsp_pkg::ADDR_W-1:0]      rd_addr,
    output logic      [bfsp_pkg::WEIGHT_BITS-1:0] rd_data
);
    import bfsp_pkg::*;

    logic [WEIGHT_BITS-1:0] mem [MAT_DEPTH];
    logic [WEIGHT_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ hw/rtl/bfsp_relax.sv @@
// Distance / parent tables and the shared add-compare relaxation unit.
// Depends on bfsp_pkg; weight arrives from bfsp_wmem in the cycle after issue.
`default_nettype none

module bfsp_relax (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire bfsp_pkg::bfsp_ctl_t             ctl,
    input  wire logic [bfsp_pkg::WEIGHT_BITS-1:0] weight,
    output bfsp_pkg::bfsp_stat_t                 stat
);
    import bfsp_pkg::*;

    logic [DIST_W-1:0]    dist_mem [MAX_NODES];
    logic [CNT_W-1:0]     par_mem  [MAX_NODES];
    logic [MAX_NODES-1:0] fin_reg;

    logic [DIST_W-1:0]    dist_rd_reg;
    logic [CNT_W-1:0]     par_rd_reg;
    logic                 fin_rd_reg;
    logic [NODE_W-1:0]    addr_d_reg;
    logic                 relax_d_reg;
    logic [DIST_W-1:0]    du_reg;

    logic [DIST_W-1:0]    alt;
    logic                 update;
    logic                 wr_en;
    logic [NODE_W-1:0]    wr_addr;
    logic [DIST_W-1:0]    wr_dist;
    logic [CNT_W-1:0]     wr_par;

    // relaxation of (u, v): row u is known reached, so only w and dist[v] matter
    assign alt    = du_reg + DIST_W'(weight);
    assign update = relax_d_reg && (weight != '0) && (!fin_rd_reg || (alt < dist_rd_reg));

    always_comb
    begin
        wr_en   = update || ctl.seed;
        wr_addr = ctl.seed ? ctl.seed_addr : addr_d_reg;
        wr_dist = ctl.seed ? '0 : alt;
        wr_par  = ctl.seed ? '0 : (CNT_W'(ctl.u) + CNT_W'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_reg     <= '0;
            relax_d_reg <= 1'b0;
        end
        else
        begin
            relax_d_reg <= ctl.relax;
            if (ctl.clear)
            begin
                fin_reg <= '0;
            end
            if (wr_en)
            begin
                fin_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            dist_mem[wr_addr] <= wr_dist;
            par_mem[wr_addr]  <= wr_par;
        end
        dist_rd_reg <= dist_mem[ctl.rd_addr];
        par_rd_reg  <= par_mem[ctl.rd_addr];
        fin_rd_reg  <= fin_reg[ctl.rd_addr];
        addr_d_reg  <= ctl.rd_addr;
        if (ctl.latch_u)
        begin
            du_reg <= dist_rd_reg;
        end
    end

    assign stat.fin      = fin_rd_reg;
    assign stat.dist_val = dist_rd_reg;
    assign stat.parent   = par_rd_reg;

endmodule

`default_nettype wire

@@ hw/rtl/bfsp_seq.sv @@
// Sequencer: pass / row / column counters and the result walk.
// Depends on bfsp_pkg and bellman_ford_shortest_paths_assert.svh.
`default_nettype none

module bfsp_seq (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire logic                        last_entry,
    input  wire logic [bfsp_pkg::SRC_W-1:0]   source_node,
    input  wire logic [bfsp_pkg::COUNT_W-1:0] node_count,
    input  wire logic                        out_ready,
    input  wire bfsp_pkg::bfsp_stat_t        status,
    output logic                             in_ready,
    output bfsp_pkg::bfsp_ctl_t              ctl
);
    import bfsp_pkg::*;

    bfsp_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  pass_reg, pass_next;
    logic [NODE_W-1:0] u_reg, u_next;
    logic [NODE_W-1:0] v_reg, v_next;

    logic [CNT_W-1:0]  n;
    logic [CNT_W-1:0]  n_m1_cnt;
    logic [NODE_W-1:0] n_m1;
    logic              src_ok;

    // effective node count, saturated
    assign n        = (32'(node_count) > MAX_NODES) ? CNT_W'(MAX_NODES) : CNT_W'(node_count);
    assign n_m1_cnt = n - CNT_W'(1);
    assign n_m1     = NODE_W'(n_m1_cnt);
    assign src_ok   = 32'(source_node) < 32'(n);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pass_reg  <= '0;
            u_reg     <= '0;
            v_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
            u_reg     <= u_next;
            v_reg     <= v_next;
        end
    end

    // next state and counters
    always_comb
    begin
        state_next = state_reg;
        pass_next  = pass_reg;
        u_next     = u_reg;
        v_next     = v_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && last_entry)
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                u_next    = '0;
                v_next    = '0;
                pass_next = CNT_W'(1);
                if (n == '0)
                begin
                    state_next = ST_IDLE;
                end
                else if (n == CNT_W'(1))
                begin
                    state_next = ST_OUT_RD;
                end
                else
                begin
                    state_next = ST_ROW_RD;
                end
            end
            ST_ROW_RD:
            begin
                state_next = ST_ROW_CHK;
            end
            ST_ROW_CHK, ST_DRAIN:
            begin
                if ((state_reg == ST_ROW_CHK) && status.fin)
                begin
                    v_next     = '0;
                    state_next = ST_SCAN;
                end
                else if (u_reg != n_m1)
                begin
                    u_next     = u_reg + NODE_W'(1);
                    state_next = ST_ROW_RD;
                end
                else if (pass_reg != n_m1_cnt)
                begin
                    u_next     = '0;
                    pass_next  = pass_reg + CNT_W'(1);
                    state_next = ST_ROW_RD;
                end
                else
                begin
                    v_next     = '0;
                    state_next = ST_OUT_RD;
                end
            end
            ST_SCAN:
            begin
                if (v_reg == n_m1)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    v_next = v_reg + NODE_W'(1);
                end
            end
            ST_OUT_RD:
            begin
                state_next = ST_OUT_LD;
            end
            ST_OUT_LD:
            begin
                state_next = ST_OUT_SEND;
            end
            ST_OUT_SEND:
            begin
                if (out_ready)
                begin
                    if (v_reg == n_m1)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        v_next     = v_reg + NODE_W'(1);
                        state_next = ST_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready      = 1'b0;
        ctl           = '0;
        ctl.rd_addr   = v_reg;
        ctl.u         = u_reg;
        ctl.seed_addr = NODE_W'(source_node);
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_INIT:
            begin
                ctl.clear = 1'b1;
                ctl.seed  = src_ok;
            end
            ST_ROW_RD:
            begin
                ctl.rd_addr = u_reg;
            end
            ST_ROW_CHK:
            begin
                ctl.latch_u = 1'b1;
            end
            ST_SCAN:
            begin
                ctl.relax = 1'b1;
            end
            ST_OUT_LD:
            begin
                ctl.out_load = 1'b1;
                ctl.out_last = (v_reg == n_m1);
            end
            ST_DRAIN, ST_OUT_RD, ST_OUT_SEND:
            begin
                in_ready = 1'b0;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

`include "bellman_ford_shortest_paths_assert.svh"

    `BFSP_ASSERT_NXT(a_run_start, in_valid && in_ready && last_entry, state_reg == ST_INIT)
    `BFSP_ASSERT_IMP(a_scan_range, state_reg == ST_SCAN, (u_reg <= n_m1) && (v_reg <= n_m1) && (pass_reg < n))
    `BFSP_ASSERT_NXT(a_skip_unreached, (state_reg == ST_ROW_CHK) && !status.fin, (state_reg == ST_ROW_RD) || (state_reg == ST_OUT_RD))

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// Self-checking testbench for bellman_ford_shortest_paths: loads random adjacency
// matrices, predicts per-node distances/parents and checks every result item.
// Depends on bfsp_pkg and the bellman_ford_shortest_paths RTL.
`timescale 1ns / 1ps

module tb;
    import bfsp_pkg::*;

    localparam int LONG_HOLD = 400;   // length of the one long park of the result side

    // One per-node result as seen on the output port
    typedef struct {
        logic [OUT_NODE_W-1:0] node;
        logic [OUT_DIST_W-1:0] dist_val;
        logic                  reach;
        logic [PARENT_W-1:0]   parent;
        logic                  is_last;
    } node_result_t;

    // Mirror of the block: weight matrix, both registers, and the queue of
    // per-node results still owed by the block.
    class path_book;
        logic [WIN_W-1:0]   weights [MAT_DEPTH];
        logic [SRC_W-1:0]   start_node;
        logic [COUNT_W-1:0] node_total;
        node_result_t       due [$];
        int                 errors;

        function new();
            start_node = '0;
            node_total = COUNT_W'(MAX_NODES);
            errors = 0;
            foreach (weights[i])
                weights[i] = '0;
        endfunction

        function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            if (idx == REG_SOURCE_NODE)
                start_node = value[SRC_W-1:0];
            else if (idx == REG_NODE_COUNT)
                node_total = value[COUNT_W-1:0];
        endfunction

        // Accepted input item: store the weight, and on the flagged item run the
        // whole shortest-path search and queue one result per node.
        function void take_entry(logic [ROW_W-1:0] row, logic [ROW_W-1:0] col,
                                 logic [WIN_W-1:0] w, logic lst);
            weights[int'(row) * MAX_NODES + int'(col)] = w;
            if (lst)
                relax_graph();
        endfunction

        function void relax_graph();
            logic [63:0]  best_len [MAX_NODES];
            bit           reached [MAX_NODES];
            int           parent [MAX_NODES];
            logic [63:0]  alt;
            logic [WIN_W-1:0] w;
            node_result_t r;
            int           n, pass, u, v, k;
            n = (node_total > MAX_NODES) ? MAX_NODES : int'(node_total);
            for (k = 0; k < MAX_NODES; k++) begin
                best_len[k] = '0;
                reached[k] = 1'b0;
                parent[k] = 0;
            end
            if (int'(start_node) < n)
                reached[start_node] = 1'b1;
            // in-place relaxation, u then v ascending, strict less-than
            for (pass = 1; pass < n; pass++)
                for (u = 0; u < n; u++)
                    for (v = 0; v < n; v++) begin
                        w = weights[u * MAX_NODES + v];
                        if (w != 0 && reached[u]) begin
                            alt = best_len[u] + 64'(w);
                            if (!reached[v] || alt < best_len[v]) begin
                                best_len[v] = alt;
                                reached[v] = 1'b1;
                                parent[v] = u + 1;
                            end
                        end
                    end
            for (k = 0; k < n; k++) begin
                r.node     = OUT_NODE_W'(k);
                r.dist_val = reached[k] ? best_len[k][OUT_DIST_W-1:0] : '0;
                r.reach    = reached[k];
                r.parent   = reached[k] ? PARENT_W'(parent[k]) : '0;
                r.is_last  = (k + 1 == n);
                due.push_back(r);
            end
        endfunction

        function void note_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        function void match_node(node_result_t got);
            node_result_t want;
            if (due.size() == 0) begin
                errors++;
                $display("%0t: stray result, expected none, got node %0d dist %0d",
                         $time, got.node, got.dist_val);
                return;
            end
            want = due.pop_front();
            note_field("node_index", 32'(want.node), 32'(got.node));
            note_field("path_distance", 32'(want.dist_val), 32'(got.dist_val));
            note_field("reachable", 32'(want.reach), 32'(got.reach));
            note_field("parent_node", 32'(want.parent), 32'(got.parent));
            note_field("last_node", 32'(want.is_last), 32'(got.is_last));
        endfunction
    endclass

    // ---------------------------------------------------------------------
    // Block ports; every input starts at a known value
    // ---------------------------------------------------------------------
    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [ROW_W-1:0]      row_index = '0;
    logic [ROW_W-1:0]      col_index = '0;
    logic [WIN_W-1:0]      edge_weight = '0;
    logic                  last_entry = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [OUT_NODE_W-1:0] node_index;
    logic [OUT_DIST_W-1:0] path_distance;
    logic                  reachable;
    logic [PARENT_W-1:0]   parent_node;
    logic                  last_node;

    path_book book;
    bit       written [MAT_DEPTH];   // matrix cells loaded so far
    int       entries_sent = 0;
    bit       no_gaps = 1'b0;        // phase-wide: both sides run flat out
    bit       park_output = 1'b0;    // result side parks on the next run

    bellman_ford_shortest_paths dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .row_index     (row_index),
        .col_index     (col_index),
        .edge_weight   (edge_weight),
        .last_entry    (last_entry),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .node_index    (node_index),
        .path_distance (path_distance),
        .reachable     (reachable),
        .parent_node   (parent_node),
        .last_node     (last_node)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Weight mix: no-edge, small, anything, and near full scale
    function automatic logic [WIN_W-1:0] pick_weight(int zero_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < zero_pct)
            return '0;
        r = $urandom_range(0, 9);
        if (r < 4)
            return WIN_W'($urandom_range(1, 15));
        if (r < 7)
            return WIN_W'($urandom_range(0, 65535));
        return WIN_W'($urandom_range(65280, 65535));
    endfunction

    // Offer one matrix item and hold it until taken. A random gap may come
    // first; valid is only lowered for that gap, never around an item.
    task automatic send_entry(input logic [ROW_W-1:0] r, input logic [ROW_W-1:0] c,
                              input logic [WIN_W-1:0] w, input logic lst);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        row_index   <= r;
        col_index   <= c;
        edge_weight <= w;
        last_entry  <= lst;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        book.take_entry(r, c, w, lst);
        written[int'(r) * MAX_NODES + int'(c)] = 1'b1;
        entries_sent++;
    endtask

    // Stop offering, wait for every owed result, then let a run that owes
    // nothing (node_count 0) wind down before touching the registers.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (book.due.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Both registers, back to back; write enable held across the pair
    task automatic set_regs(input logic [SRC_W-1:0] src, input logic [COUNT_W-1:0] cnt);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_SOURCE_NODE;
        cfg_wdata <= CFG_DATA_W'(src);
        @(posedge clk);
        cfg_addr  <= REG_NODE_COUNT;
        cfg_wdata <= CFG_DATA_W'(cnt);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        book.set_reg(REG_SOURCE_NODE, CFG_DATA_W'(src));
        book.set_reg(REG_NODE_COUNT, CFG_DATA_W'(cnt));
    endtask

    // Well-formed load: every cell of the n x n corner with fresh weights,
    // sprinkled with stray cells anywhere, then a flagged item anywhere.
    task automatic load_graph(input int n, input int zero_pct);
        int u, v;
        for (u = 0; u < n; u++)
            for (v = 0; v < n; v++) begin
                if ($urandom_range(0, 9) == 0)
                    send_entry(ROW_W'($urandom_range(0, 15)), ROW_W'($urandom_range(0, 15)),
                               pick_weight(zero_pct), 1'b0);
                send_entry(ROW_W'(u), ROW_W'(v), pick_weight(zero_pct), 1'b0);
            end
        send_entry(ROW_W'($urandom_range(0, 15)), ROW_W'($urandom_range(0, 15)),
                   pick_weight(zero_pct), 1'b1);
    endtask

    // ---------------------------------------------------------------------
    // Result side: checks each accepted item and throttles out_ready.
    // One run is parked (LONG_HOLD) so the block backs up and the
    // sender's next items sit unaccepted.
    // ---------------------------------------------------------------------
    initial begin : result_side
        int           hold_left;
        node_result_t got;
        hold_left = 0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (out_valid && out_ready) begin
                got.node     = node_index;
                got.dist_val = path_distance;
                got.reach    = reachable;
                got.parent   = parent_node;
                got.is_last  = last_node;
                book.match_node(got);
                hold_left = pick_gap();
            end else if (!out_valid && hold_left == 0 && $urandom_range(0, 19) == 0) begin
                hold_left = pick_gap();
            end
            if (park_output && out_valid && hold_left == 0) begin
                park_output = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Hard stop in case the block hangs
    initial begin
        #(5_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------
    initial begin : stimulus
        int               phase, n, r, u, v;
        logic [SRC_W-1:0] src;
        logic [COUNT_W-1:0] cnt;
        bit               chain;

        book = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // -- Directed --------------------------------------------------
        // Two nodes, a full-scale edge 0->1 and a unit edge 1->0; flagged item lands
        // on the far corner cell, outside the nodes in use.
        set_regs(4'd0, 5'd2);
        send_entry(4'd0, 4'd0, 16'd0, 1'b0);
        send_entry(4'd0, 4'd1, 16'hFFFF, 1'b0);
        send_entry(4'd1, 4'd0, 16'd1, 1'b0);
        send_entry(4'd1, 4'd1, 16'd0, 1'b0);
        send_entry(4'd15, 4'd15, 16'hFFFF, 1'b1);

        // Zero nodes: the run owes nothing
        settle();
        set_regs(4'd0, 5'd0);
        send_entry(4'd0, 4'd0, 16'd0, 1'b1);

        // Source outside the nodes in use: everything unreachable
        settle();
        set_regs(4'd5, 5'd3);
        send_entry(4'd0, 4'd2, 16'd5, 1'b0);
        send_entry(4'd1, 4'd2, 16'd9, 1'b0);
        send_entry(4'd2, 4'd0, 16'd3, 1'b0);
        send_entry(4'd2, 4'd1, 16'd4, 1'b0);
        send_entry(4'd2, 4'd2, 16'hFFFF, 1'b0);
        send_entry(4'd1, 4'd2, 16'd7, 1'b1);

        // Source 2: node 0 is reached at 3 directly and again at 3 via node
        // 1, so the tie must keep parent 3; self loop never improves.
        settle();
        set_regs(4'd2, 5'd3);
        send_entry(4'd2, 4'd1, 16'd2, 1'b1);

        // -- Random runs on small graphs -------------------------------
        phase = 0;
        chain = 1'b0;
        n = 0;
        while (entries_sent < 240) begin
            if (!chain) begin
                settle();
                r = $urandom_range(0, 99);
                if (r < 6)
                    n = 0;
                else if (r < 14)
                    n = 1;
                else if (r < 80)
                    n = $urandom_range(2, 5);
                else
                    n = $urandom_range(6, 8);
                if ($urandom_range(0, 4) == 0 || n == 0)
                    src = SRC_W'($urandom_range(0, 15));
                else
                    src = SRC_W'($urandom_range(0, n - 1));
                cnt = COUNT_W'(n);
                no_gaps = ($urandom_range(0, 3) == 0);
                set_regs(src, cnt);
            end
            // Phase 3 parks the result side and rolls straight into the next
            // load with the same settings, so those items back up at input.
            chain = (phase == 3);
            if (chain) begin
                no_gaps = 1'b0;
                park_output = 1'b1;
            end
            load_graph(n, 35);
            phase++;
        end

        // -- Full size, node_count past the top (saturates to 16) ---------
        // Every cell still unloaded gets a mostly-empty weight, then a chain
        // of full-scale edges drives the far distances toward 20 bits.
        settle();
        no_gaps = 1'b0;
        set_regs(4'd0, 5'd31);
        for (u = 0; u < MAX_NODES; u++)
            for (v = 0; v < MAX_NODES; v++)
                if (!written[u * MAX_NODES + v])
                    send_entry(ROW_W'(u), ROW_W'(v), pick_weight(90), 1'b0);
        for (u = 0; u < MAX_NODES - 1; u++)
            send_entry(ROW_W'(u), ROW_W'(u + 1), 16'hFFFF, 1'b0);
        send_entry(4'd15, 4'd0, 16'hFFFF, 1'b1);

        // -- Full size again, exact top count, last node as source --------
        settle();
        set_regs(4'd15, 5'd16);
        for (u = 0; u < 8; u++)
            send_entry(ROW_W'($urandom_range(0, 15)), ROW_W'($urandom_range(0, 15)),
                       pick_weight(50), 1'b0);
        send_entry(ROW_W'($urandom_range(0, 15)), ROW_W'($urandom_range(0, 15)),
                   pick_weight(50), 1'b1);

        // Drain, then a quiet tail to catch anything extra
        settle();
        repeat (200) @(posedge clk);
        if (book.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/bfsp_pkg.sv
hw/rtl/bfsp_wmem.sv
hw/rtl/bfsp_relax.sv
hw/rtl/bfsp_seq.sv
hw/rtl/bellman_ford_shortest_paths.sv
dv/tb.sv
